### hw/rtl/wto_pkg.sv
package wto_pkg;

  // Table geometry and number formats
  localparam int TABLE_DEPTH   = 1024;
  localparam int SAMPLE_BITS   = 16;
  localparam int PHASE_BITS    = 32;
  localparam int FRAC_BITS     = 16;
  localparam int INC_FRAC_BITS = 40;
  localparam int FREQ_W        = 32;
  localparam int RECIP_W       = 32;
  localparam int LEN_W         = 11;
  localparam int TADDR_W       = 10;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(89478);
  localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(1024);

  // Register index, taken from paddr[2]
  localparam logic REG_RECIP = 1'b0;
  localparam logic REG_LEN   = 1'b1;

  localparam logic [1:0] MODE_PRODUCE = 2'd0;
  localparam logic [1:0] MODE_WRITE   = 2'd1;
  localparam logic [1:0] MODE_SET     = 2'd2;

  typedef enum logic [1:0] {
    CMD_PRODUCE = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_SET     = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e                    kind;
    logic [FREQ_W-1:0]       frequency;
    logic [TADDR_W-1:0]      table_address;
    logic [SAMPLE_BITS-1:0]  table_data;
    logic [PHASE_BITS-1:0]   phase_value;
  } cmd_t;

  typedef struct packed {
    logic [RECIP_W-1:0] recip_sample_rate;
    logic [LEN_W-1:0]   table_length;
  } cfg_t;

endpackage

### hw/rtl/wto_if.sv
interface wto_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] frequency;
  logic [9:0]  table_address;
  logic [15:0] table_data;
  logic [31:0] phase_value;

  modport source (
    output valid, mode, frequency, table_address, table_data, phase_value,
    input  ready
  );
  modport sink (
    input  valid, mode, frequency, table_address, table_data, phase_value,
    output ready
  );
endinterface

interface wto_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_out;
  logic [31:0] phase_out;

  modport source (
    output valid, sample_out, phase_out,
    input  ready
  );
  modport sink (
    input  valid, sample_out, phase_out,
    output ready
  );
endinterface

### hw/rtl/wto_front.sv
module wto_front (
  wto_in_if.sink         in_if,
  input  logic           full_i,
  output logic           push_o,
  output wto_pkg::cmd_t  cmd_o
);

  logic take;

  assign in_if.ready = !full_i;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    cmd_o.kind          = wto_pkg::CMD_PRODUCE;
    cmd_o.frequency     = in_if.frequency;
    cmd_o.table_address = in_if.table_address;
    cmd_o.table_data    = in_if.table_data;
    cmd_o.phase_value   = in_if.phase_value;
    push_o              = 1'b0;
    case (in_if.mode)
      wto_pkg::MODE_PRODUCE: begin
        cmd_o.kind = wto_pkg::CMD_PRODUCE;
        push_o     = take;
      end
      wto_pkg::MODE_WRITE: begin
        cmd_o.kind = wto_pkg::CMD_WRITE;
        push_o     = take;
      end
      wto_pkg::MODE_SET: begin
        cmd_o.kind = wto_pkg::CMD_SET;
        push_o     = take;
      end
      // unused mode: accept and drop
      default: push_o = 1'b0;
    endcase
  end

endmodule

### hw/rtl/wto_queue.sv
module wto_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wto_pkg::cmd_t  cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output wto_pkg::cmd_t  head_o,
  output logic           empty_o
);

  localparam int PTR_W = (wto_pkg::QUEUE_DEPTH > 1) ? $clog2(wto_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(wto_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(wto_pkg::QUEUE_DEPTH - 1);

  wto_pkg::cmd_t    slot_q [wto_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(wto_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LAST) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LAST) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(wto_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule

### hw/rtl/wto_back.sv
module wto_back #(
  parameter int TABLE_DEPTH = wto_pkg::TABLE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wto_pkg::cfg_t  cfg_i,
  input  wto_pkg::cmd_t  head_i,
  input  logic           empty_i,
  output logic           pop_o,
  wto_out_if.source      out_if
);

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SB    = wto_pkg::SAMPLE_BITS;
  localparam int PB    = wto_pkg::PHASE_BITS;
  localparam int FB    = wto_pkg::FRAC_BITS;
  localparam int LW    = wto_pkg::LEN_W;
  localparam int IW    = wto_pkg::INC_FRAC_BITS;
  localparam int POSW  = PB + LW;
  localparam int IPW   = SB + FB + 2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_RD   = 5'b00100,
    S_INT  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [SB-1:0]         mem [TABLE_DEPTH];
  logic [PB-1:0]         phase_q, phase_d;
  logic [PB-1:0]         ph_q;
  logic [wto_pkg::FREQ_W-1:0] freq_q;
  logic [POSW-1:0]       pos_q;
  logic [IW-1:0]         prod_q;
  logic [SB-1:0]         y0_q, y1_q;
  logic [FB-1:0]         frac_q;
  logic signed [IPW-1:0] ip_q;
  logic                  out_valid_q;
  logic [SB-1:0]         sample_q;
  logic [PB-1:0]         phase_out_q;

  logic [LW-1:0]         len, lenm1, idx;
  logic [AW-1:0]         ra0, ra1;
  logic                  we, re, load_out, slot_free;
  logic signed [SB:0]    diff;
  logic signed [IPW-1:0] ip_d;

  // clamp table length to [2, TABLE_DEPTH]
  always_comb begin
    len = cfg_i.table_length;
    if (len < LW'(2)) begin
      len = LW'(2);
    end
    if (32'(len) > 32'(TABLE_DEPTH)) begin
      len = LW'(TABLE_DEPTH);
    end
    lenm1 = len - 1'b1;
  end

  assign idx  = pos_q[PB +: LW];
  assign ra0  = AW'(idx);
  assign ra1  = ra0 + 1'b1;
  assign diff = $signed({y1_q[SB-1], y1_q}) - $signed({y0_q[SB-1], y0_q});
  assign ip_d = diff * $signed({1'b0, frac_q});

  assign slot_free = !out_valid_q || out_if.ready;

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (head_i.kind)
            wto_pkg::CMD_PRODUCE: state_d = S_MUL;
            wto_pkg::CMD_WRITE:   we = (32'(head_i.table_address) < 32'(TABLE_DEPTH));
            wto_pkg::CMD_SET:     phase_d = head_i.phase_value;
            default: ;
          endcase
        end
      end
      S_MUL: state_d = S_RD;
      S_RD: begin
        // advance phase, wrapping modulo one waveform period
        phase_d = ph_q + prod_q[IW-1 -: PB];
        re      = 1'b1;
        state_d = S_INT;
      end
      S_INT: state_d = S_OUT;
      S_OUT: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[AW'(head_i.table_address)] <= head_i.table_data;
    end
    if (re) begin
      y0_q <= mem[ra0];
      y1_q <= mem[ra1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.kind == wto_pkg::CMD_PRODUCE) begin
      freq_q <= head_i.frequency;
    end
    if (state_q == S_MUL) begin
      ph_q   <= phase_q;
      pos_q  <= POSW'(phase_q) * POSW'(lenm1);
      // sign-extend the frequency so negative steps wrap the phase backward
      prod_q <= IW'($signed(freq_q)) * IW'(cfg_i.recip_sample_rate);
    end
    if (re) begin
      frac_q <= pos_q[PB-1 -: FB];
    end
    if (state_q == S_INT) begin
      ip_q <= ip_d;
    end
    if (load_out) begin
      sample_q    <= y0_q + ip_q[FB +: SB];
      phase_out_q <= ph_q;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.sample_out = sample_q;
  assign out_if.phase_out  = phase_out_q;

  a_rise_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result shown without interpolation step");

  a_phase_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(phase_q) |-> ($past(state_q == S_RD) ||
      $past(pop_o && head_i.kind == wto_pkg::CMD_SET)))
    else $error("phase changed outside advance or set");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (idx < lenm1))
    else $error("table index beyond interpolation range");

endmodule

### hw/rtl/wavetable_oscillator.sv
// Channel  Dir  Handshake     Payload
// in_if    in   valid/ready   mode, frequency, table_address, table_data, phase_value
// out_if   out  valid/ready   sample_out, phase_out
// apb      in   psel/penable  paddr[2] selects recip_sample_rate or table_length
//
// Input is taken every cycle while the two-entry command queue has room.
// The back end does a table write or phase set as it pops it; a produce item
// goes through pop, multiply, table read, interpolate multiply and output load.
// Reset clears the phase, the queue and the output slot; table contents are
// undefined until written. A stalled output holds the back end in its last
// step; the front keeps filling the queue until it is full.
module wavetable_oscillator #(
  parameter int TABLE_DEPTH = wto_pkg::TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wto_in_if.sink      in_if,
  wto_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [wto_pkg::RECIP_W-1:0] recip_q;
  logic [wto_pkg::LEN_W-1:0]   len_q;
  logic                        cfg_we;
  wto_pkg::cfg_t               cfg;
  wto_pkg::cmd_t               push_cmd, head;
  logic                        push, pop, full, empty;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recip_q <= wto_pkg::RECIP_RESET;
      len_q   <= wto_pkg::LEN_RESET;
    end else if (cfg_we) begin
      case (paddr[2])
        wto_pkg::REG_RECIP: recip_q <= pwdata[wto_pkg::RECIP_W-1:0];
        wto_pkg::REG_LEN:   len_q   <= pwdata[wto_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      wto_pkg::REG_RECIP: prdata = 32'(recip_q);
      wto_pkg::REG_LEN:   prdata = 32'(len_q);
      default:            prdata = '0;
    endcase
  end

  assign cfg.recip_sample_rate = recip_q;
  assign cfg.table_length      = len_q;

  wto_front u_front (
    .in_if  (in_if),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  wto_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  wto_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule

### dv/wavetable_oscillator_test.sv
module wavetable_oscillator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wto_pkg::*;

  localparam logic [1:0] MODE_NOP   = 2'd3;
  localparam logic [2:0] ADDR_RECIP = {REG_RECIP, 2'b00};
  localparam logic [2:0] ADDR_LEN   = {REG_LEN, 2'b00};

  localparam int NUM_SETTINGS      = 9;
  localparam int REQS_PER_SETTING  = 32;
  localparam int HOLD_OFF_CYCLES   = 300;
  localparam int SETTLE_CYCLES     = 12;

  typedef struct packed {
    logic [15:0] sample;
    logic [31:0] phase;
  } osc_out_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] frequency;
    logic [9:0]  address;
    logic [15:0] data;
    logic [31:0] phase;
    bit          typed;
    osc_out_t    typed_out;
  } osc_req_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  wto_in_if  in_ch ();
  wto_out_if out_ch ();

  wavetable_oscillator DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the oscillator state and registers
  logic [31:0]          osc_phase;
  logic [15:0]          wave_mem [TABLE_DEPTH];
  bit                   wave_ok [TABLE_DEPTH];
  logic [31:0]          osc_recip;
  logic [10:0]          osc_len;

  osc_out_t expected_samples [$];
  osc_req_t directed_reqs [$];

  int  error_count;
  int  n_produce;
  int  n_write;
  int  n_set;
  int  n_ignored;
  int  n_checked;
  bit  no_idle;
  bit  hold_off_go;
  int  hold_left;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic bit predict_sample(input osc_req_t c, output osc_out_t res);
    logic [10:0]        len;
    logic [63:0]        pos;
    logic [31:0]        idx;
    logic [15:0]        frac;
    logic signed [15:0] y0;
    logic signed [15:0] y1;
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [33:0] q;
    logic signed [63:0] inc_full;
    res = '0;
    case (c.mode)
      MODE_WRITE: begin
        wave_mem[c.address] = c.data;
        wave_ok[c.address] = 1'b1;
        return 1'b0;
      end
      MODE_SET: begin
        osc_phase = c.phase;
        return 1'b0;
      end
      MODE_PRODUCE: begin
        len = osc_len;
        if (len < 11'd2) len = 11'd2;
        if (len > TABLE_DEPTH) len = 11'(TABLE_DEPTH);
        pos = {32'b0, osc_phase} * {53'b0, len - 11'd1};
        idx = pos[63:32];
        frac = pos[31:16];
        if (idx > 32'(len - 11'd2)) idx = 32'(len - 11'd2);
        y0 = wave_mem[idx];
        y1 = wave_mem[idx + 1];
        diff = y1 - y0;
        prod = diff * $signed({1'b0, frac});
        q = prod >>> FRAC_BITS;
        res.sample = y0 + q[15:0];
        res.phase = osc_phase;
        // increment has 40 fraction bits; keep the top 32 of them
        inc_full = longint'($signed(c.frequency)) * longint'({32'b0, osc_recip});
        osc_phase = osc_phase + inc_full[39:8];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Lower table entry that a produce request taken now would read
  function automatic int unsigned read_index();
    logic [10:0] len;
    logic [63:0] pos;
    len = osc_len;
    if (len < 11'd2) len = 11'd2;
    if (len > TABLE_DEPTH) len = 11'(TABLE_DEPTH);
    pos = {32'b0, osc_phase} * {53'b0, len - 11'd1};
    if (pos[63:32] > 32'(len - 11'd2)) return 32'(len - 11'd2);
    return pos[63:32];
  endfunction

  function automatic osc_req_t mk_req(input logic [1:0] mode, input logic [31:0] freq,
                                      input logic [9:0] address, input logic [15:0] data,
                                      input logic [31:0] phase, input bit typed = 1'b0,
                                      input logic [15:0] t_sample = '0,
                                      input logic [31:0] t_phase = '0);
    osc_req_t c;
    c.mode = mode;
    c.frequency = freq;
    c.address = address;
    c.data = data;
    c.phase = phase;
    c.typed = typed;
    c.typed_out.sample = t_sample;
    c.typed_out.phase = t_phase;
    return c;
  endfunction

  function automatic osc_req_t rand_req();
    osc_req_t    c;
    int unsigned pick;
    c = mk_req(MODE_PRODUCE, $urandom(), 10'($urandom()), 16'($urandom()), $urandom());
    case ($urandom_range(3))
      0: ;
      1: c.frequency = 32'($signed($urandom_range(131071)) - 65536);
      2: begin
        pick = $urandom_range(4);
        c.frequency = (pick == 0) ? 32'h7FFF_FFFF : (pick == 1) ? 32'h8000_0000 :
                      (pick == 2) ? 32'hFFFF_FFFF : (pick == 3) ? 32'd0 : 32'd1;
      end
      default: c.frequency = 32'($urandom_range(20, 20000)) << 8;
    endcase
    pick = $urandom_range(99);
    if (pick < 62) c.mode = MODE_PRODUCE;
    else if (pick < 78) c.mode = MODE_WRITE;
    else if (pick < 93) c.mode = MODE_SET;
    else c.mode = MODE_NOP;
    return c;
  endfunction

  // Present one request, hold it until taken, then predict and idle at random
  task automatic send(input osc_req_t c);
    osc_out_t pred;
    bit       has_result;
    in_ch.valid <= 1'b1;
    in_ch.mode <= c.mode;
    in_ch.frequency <= c.frequency;
    in_ch.table_address <= c.address;
    in_ch.table_data <= c.data;
    in_ch.phase_value <= c.phase;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    has_result = predict_sample(c, pred);
    if (has_result) begin
      if (c.typed) expected_samples.push_back(c.typed_out);
      else expected_samples.push_back(pred);
    end
    case (c.mode)
      MODE_PRODUCE: n_produce++;
      MODE_WRITE:   n_write++;
      MODE_SET:     n_set++;
      default:      n_ignored++;
    endcase
    if (!no_idle && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Write unwritten entries a produce request would read, then send the request
  task automatic issue(input osc_req_t c);
    int unsigned idx;
    if (c.mode == MODE_PRODUCE) begin
      idx = read_index();
      for (int k = 0; k < 2; k++) begin
        if (!wave_ok[idx + k])
          send(mk_req(MODE_WRITE, $urandom(), 10'(idx + k), 16'($urandom()), $urandom()));
      end
    end
    send(c);
  endtask

  task automatic wait_results();
    while (expected_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    if (addr == ADDR_RECIP) osc_recip = data;
    else if (addr == ADDR_LEN) osc_len = data[10:0];
  endtask

  // Result sink: random stalls, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= 12);
      end
    end
  end

  always @(posedge clk_i) begin
    osc_out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected sample: sample_out %h phase_out %h",
               out_ch.sample_out, out_ch.phase_out);
        error_count++;
      end else begin
        want = expected_samples.pop_front();
        n_checked++;
        if (out_ch.sample_out !== want.sample) begin
          $error("sample_out: expected %h, actual %h", want.sample, out_ch.sample_out);
          error_count++;
        end
        if (out_ch.phase_out !== want.phase) begin
          $error("phase_out: expected %h, actual %h", want.phase, out_ch.phase_out);
          error_count++;
        end
      end
    end
  end

  initial begin
    int          n;
    logic [31:0] recip;
    logic [10:0] len;
    osc_req_t    c;

    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_NOP;
    in_ch.frequency <= '0;
    in_ch.table_address <= '0;
    in_ch.table_data <= '0;
    in_ch.phase_value <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    error_count = 0;
    n_produce = 0;
    n_write = 0;
    n_set = 0;
    n_ignored = 0;
    n_checked = 0;
    no_idle = 1'b0;
    hold_off_go = 1'b0;
    osc_phase = '0;
    osc_recip = RECIP_RESET;
    osc_len = LEN_RESET;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase is still zero after reset; writes leave it alone
    directed_reqs.push_back(mk_req(MODE_WRITE, 32'd0, 10'd0, 16'h7FFF, 32'd0));
    directed_reqs.push_back(mk_req(MODE_WRITE, 32'd0, 10'd1, 16'h8000, 32'd0));
    directed_reqs.push_back(mk_req(MODE_WRITE, 32'd0, 10'd1022, 16'h8000, 32'd0));
    directed_reqs.push_back(mk_req(MODE_WRITE, 32'd0, 10'd1023, 16'h7FFF, 32'd0));
    directed_reqs.push_back(mk_req(MODE_PRODUCE, 32'd0, '0, '0, '0, 1'b1, 16'h7FFF, 32'd0));
    directed_reqs.push_back(mk_req(MODE_PRODUCE, 32'h7FFF_FFFF, '0, '0, '0,
                                   1'b1, 16'h7FFF, 32'd0));
    directed_reqs.push_back(mk_req(MODE_PRODUCE, 32'h8000_0000, '0, '0, '0));
    directed_reqs.push_back(mk_req(MODE_PRODUCE, 32'd0, '0, '0, '0));
    directed_reqs.push_back(mk_req(MODE_SET, 32'd0, '0, '0, 32'hFFFF_FFFF));
    directed_reqs.push_back(mk_req(MODE_PRODUCE, 32'd0, '0, '0, '0));
    directed_reqs.push_back(mk_req(MODE_SET, 32'd0, '0, '0, 32'h8000_0000));
    directed_reqs.push_back(mk_req(MODE_PRODUCE, 32'hFFFF_FFFF, '0, '0, '0));
    directed_reqs.push_back(mk_req(MODE_NOP, 32'hFFFF_FFFF, 10'h3FF, 16'hFFFF, 32'hFFFF_FFFF));
    directed_reqs.push_back(mk_req(MODE_PRODUCE, 32'd1, '0, '0, '0));
    directed_reqs.push_back(mk_req(MODE_SET, 32'd0, '0, '0, 32'd0));
    directed_reqs.push_back(mk_req(MODE_PRODUCE, 32'd0, '0, '0, '0, 1'b1, 16'h7FFF, 32'd0));
    directed_reqs.push_back(mk_req(MODE_WRITE, 32'd0, 10'h3FF, 16'h0000, 32'd0));
    directed_reqs.push_back(mk_req(MODE_WRITE, 32'd0, 10'd0, 16'h0000, 32'd0));
    directed_reqs.push_back(mk_req(MODE_SET, 32'd0, '0, '0, 32'hFFFF_FFFF));
    directed_reqs.push_back(mk_req(MODE_PRODUCE, 32'd256, '0, '0, '0));
    foreach (directed_reqs[i]) issue(directed_reqs[i]);

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      in_ch.valid <= 1'b0;
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      recip = ($urandom_range(1) == 0) ? $urandom() : 32'($urandom_range(1, 500000));
      case (p)
        0: begin recip = 32'd0; len = 11'd2; end
        1: begin recip = 32'hFFFF_FFFF; len = 11'd1024; end
        2: len = 11'd0;
        3: len = 11'd2047;
        4: len = 11'd1;
        5: len = 11'($urandom_range(2, 1024));
        6: len = 11'd1025;
        7: begin recip = 32'd1; len = 11'd3; end
        default: begin recip = RECIP_RESET; len = LEN_RESET; end
      endcase
      apb_write(ADDR_RECIP, recip);
      apb_write(ADDR_LEN, {21'b0, len});
      no_idle = (p == 3);
      n = 0;
      while (n < REQS_PER_SETTING) begin
        // stall the sink long enough to back up the queue into the input
        if (p == 1 && n == 10) hold_off_go = 1'b1;
        if (p == 4 && n == 25) begin
          in_ch.valid <= 1'b0;
          wait_results();
          @(posedge clk_i);
        end
        c = rand_req();
        issue(c);
        if (c.mode != MODE_NOP) n++;
      end
    end

    in_ch.valid <= 1'b0;
    no_idle = 1'b0;
    wait_results();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d produce, %0d table write, %0d phase set and %0d unused-mode requests,",
             n_produce, n_write, n_set, n_ignored);
    $display("  %0d samples checked across %0d register settings", n_checked, NUM_SETTINGS + 1);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
